/* rtl/matrix_vector_multiply_assert.svh */
// Assertion macros used by the checker of the matrix-vector multiplier.
`ifndef MATRIX_VECTOR_MULTIPLY_ASSERT_SVH
`define MATRIX_VECTOR_MULTIPLY_ASSERT_SVH

// Implication checked in the same cycle, off while reset is high.
`define MVM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked in the cycle after the antecedent, off while reset is high.
`define MVM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/mvm_pkg.sv */
// Package with the field widths, payload types, codes and the command and status types of the matrix-vector multiplier.
package mvm_pkg;

   // Field widths fixed by the interface.
   localparam int unsigned DATA_W = 32;
   localparam int unsigned COL_W  = 16;

   // Item function codes.
   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_MATRIX = 1'b1;

   // Result status codes.
   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_MISMATCH = 1'b1;

   // Saturation point of the column counter.
   localparam logic [COL_W-1:0] COL_MAX = {COL_W{1'b1}};

   typedef struct packed {
      logic                     func;
      logic signed [DATA_W-1:0] value;
      logic                     end_mark;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] row_sum;
      logic [COL_W-1:0]         row_number;
      logic                     status;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_vec;
      logic start_row;
      logic multiply;
      logic accumulate;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic end_mark;
      logic out_free;
   } sts_type;

endpackage

/* rtl/mvm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mvm_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64,
   parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* rtl/mvm_ctrl.sv */
// Controller state machine that sequences each item through the datapath.
module mvm_ctrl
   import mvm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_func,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_ACC  = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // Next state and commands.
   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_MATRIX) begin
                  cmd.start_row = 1'b1;
                  state_in      = ST_READ;
               end else begin
                  cmd.load_vec = 1'b1;
               end
            end
         end
         ST_READ: begin
            cmd.multiply = 1'b1;
            state_in     = ST_ACC;
         end
         ST_ACC: begin
            cmd.accumulate = 1'b1;
            state_in       = sts.end_mark ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/mvm_dp.sv */
// Datapath: vector store, multiplier, row accumulator, counters and result register.
module mvm_dp
   import mvm_pkg::*;
#(
   parameter int unsigned MAX_LEN = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  cmd_type cmd,
   output sts_type sts,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int unsigned ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int unsigned LEN_W  = $clog2(MAX_LEN + 1);

   // Control and counter registers.
   logic [LEN_W-1:0]  load_index_ff, load_index_in;
   logic [LEN_W-1:0]  vec_len_ff, vec_len_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [COL_W-1:0]  row_ff, row_in;
   logic              end_ff, end_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [DATA_W-1:0] value_ff;
   logic [DATA_W-1:0] prod_ff;
   rsp_type           rsp_ff;

   logic              wr_en;
   logic [LEN_W-1:0]  load_next;
   logic [DATA_W-1:0] rd_data;
   logic [COL_W-1:0]  vec_len_ext;
   logic              in_range;
   logic              mismatch;

   assign vec_len_ext = COL_W'(vec_len_ff);
   assign in_range    = (col_ff < vec_len_ext);
   assign mismatch    = (col_ff != vec_len_ext);

   // Elements past the store depth are dropped.
   assign wr_en     = cmd.load_vec && (load_index_ff < LEN_W'(MAX_LEN));
   assign load_next = wr_en ? (load_index_ff + LEN_W'(1)) : load_index_ff;

   mvm_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_LEN)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (load_index_ff[ADDR_W-1:0]),
      .wr_data (req_data.value),
      .rd_addr (col_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // Next values of the control and counter registers.
   always_comb begin
      load_index_in = load_index_ff;
      vec_len_in    = vec_len_ff;
      col_in        = col_ff;
      acc_in        = acc_ff;
      row_in        = row_ff;
      end_in        = end_ff;
      rsp_valid_in  = rsp_valid_ff;

      // A finished result leaves on its transfer.
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.load_vec) begin
         load_index_in = load_next;
         // The last vector element fixes the length and restarts the matrix.
         if (req_data.end_mark) begin
            vec_len_in    = load_next;
            load_index_in = '0;
            col_in        = '0;
            acc_in        = '0;
            row_in        = '0;
         end
      end

      if (cmd.start_row) begin
         end_in = req_data.end_mark;
      end

      // Columns beyond the vector add nothing; the column count saturates.
      if (cmd.accumulate) begin
         if (in_range) begin
            acc_in = acc_ff + prod_ff;
         end
         if (col_ff != COL_MAX) begin
            col_in = col_ff + COL_W'(1);
         end
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         row_in       = row_ff + COL_W'(1);
         col_in       = '0;
         acc_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_index_ff <= '0;
         vec_len_ff    <= '0;
         col_ff        <= '0;
         acc_ff        <= '0;
         row_ff        <= '0;
         end_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         load_index_ff <= load_index_in;
         vec_len_ff    <= vec_len_in;
         col_ff        <= col_in;
         acc_ff        <= acc_in;
         row_ff        <= row_in;
         end_ff        <= end_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Element capture, product register and result register.
   always_ff @(posedge clock) begin
      if (cmd.start_row) begin
         value_ff <= req_data.value;
      end
      if (cmd.multiply) begin
         prod_ff <= value_ff * rd_data;
      end
      if (cmd.emit) begin
         rsp_ff.row_sum    <= mismatch ? '0 : acc_ff;
         rsp_ff.row_number <= row_ff;
         rsp_ff.status     <= mismatch ? STATUS_MISMATCH : STATUS_OK;
      end
   end

   assign sts.end_mark = end_ff;
   assign sts.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;

endmodule

/* rtl/matrix_vector_multiply.sv */
// Top level of the integer matrix-vector multiplier.
//
//   Channel   Ports                         Direction   Carries
//   request   req_valid/req_ready/req_data  in          vector or matrix element
//   response  rsp_valid/rsp_ready/rsp_data  out         row sum, row number, status
//
// A vector element is written to the store as it transfers.
// A matrix element passes through a store read, a registered multiply and
// an accumulate, and at a row end also through a load of the result register.
// A row end waits while the result register still holds an untaken result.
// Reset is synchronous and clears all counters; the store keeps no reset value.
module matrix_vector_multiply
   import mvm_pkg::*;
#(
   parameter int unsigned MAX_LEN = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;

   // Sequencer.
   mvm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_data.func),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Storage and arithmetic.
   mvm_dp #(
      .MAX_LEN (MAX_LEN)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* rtl/mvm_checker.sv */
// Port-level checker for the matrix-vector multiplier, bound to the top level.
`include "matrix_vector_multiply_assert.svh"

module mvm_checker
   import mvm_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A stalled result stays and holds its payload.
   `MVM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result changed while stalled")

   // A length mismatch always reports a zero sum.
   `MVM_ASSERT_SAME(a_mismatch_zero, clock, reset, rsp_valid && (rsp_data.status == STATUS_MISMATCH), rsp_data.row_sum == '0, "mismatch with non-zero sum")

   // A matrix element keeps the request side busy in the following cycle.
   `MVM_ASSERT_NEXT(a_matrix_busy, clock, reset, req_valid && req_ready && (req_data.func == FUNC_MATRIX), !req_ready, "ready while matrix element in work")

   // A vector element never produces a result straight away.
   `MVM_ASSERT_NEXT(a_load_no_rsp, clock, reset, req_valid && req_ready && (req_data.func == FUNC_LOAD), !$rose(rsp_valid), "result raised by vector load")

endmodule

bind matrix_vector_multiply mvm_checker u_checker (.*);
